[rtl/lwse_pkg.sv]
package lwse_pkg;

   // Field widths of the request and response words.
   localparam int BIN_W  = 13;
   localparam int MAG_W  = 24;
   localparam int FRAC_W = 16;
   localparam int SUM_W  = 37;
   localparam int STAT_W = 2;

   // Smallest half-width of the smoothing window.
   localparam logic [BIN_W-1:0] MIN_HALF_WIDTH = BIN_W'(3);

   // Register reset values.
   localparam logic [BIN_W-1:0]  BIN_COUNT_RESET      = BIN_W'(1025);
   localparam logic [FRAC_W-1:0] WIDTH_FRACTION_RESET = FRAC_W'(16384);

   // Register indexes on the configuration port.
   localparam logic CSR_BIN_COUNT      = 1'b0;
   localparam logic CSR_WIDTH_FRACTION = 1'b1;

   // Request kinds.
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Response status codes.
   localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_RANGE   = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_PENDING = 2'd2;

   typedef struct packed {
      logic              req_type;
      logic [BIN_W-1:0]  bin_index;
      logic [MAG_W-1:0]  magnitude;
   } request_word_type;

   typedef struct packed {
      logic [MAG_W-1:0]  envelope;
      logic [STAT_W-1:0] status;
   } response_word_type;

   // Query sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HALF,
      ST_READ_HI,
      ST_READ_LO,
      ST_DIVIDE
   } lwse_state_type;

endpackage

[rtl/lwse_ram.sv]
module lwse_ram #(
   parameter int WIDTH = 37,
   parameter int DEPTH = 4098
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lwse_divider.sv]
module lwse_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [lwse_pkg::SUM_W-1:0] dividend,
   input  logic [lwse_pkg::BIN_W-1:0] divisor,
   output logic                       done,
   output logic [lwse_pkg::SUM_W-1:0] quotient
);

   import lwse_pkg::*;

   localparam int CNT_W = $clog2(SUM_W);

   logic             active_ff, active_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [BIN_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [BIN_W-1:0] div_ff, div_in;
   logic [BIN_W:0]   trial;
   logic [BIN_W:0]   diff;

   // One restoring step a cycle: the dividend shifts out of the top of the
   // quotient register while quotient bits shift in at the bottom.
   always_comb begin
      trial     = {rem_ff, quo_ff[SUM_W-1]};
      diff      = trial - {1'b0, div_ff};
      active_in = active_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      div_in    = div_ff;
      if (start) begin
         active_in = 1'b1;
         count_in  = CNT_W'(SUM_W - 1);
         rem_in    = '0;
         quo_in    = dividend;
         div_in    = divisor;
      end else if (active_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[BIN_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[BIN_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         count_in = count_ff - CNT_W'(1);
         if (count_ff == '0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         count_ff  <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/log_width_spectral_envelope.sv]
// Channel    Handshake                    Word
// request    start in, busy out           req_data (request_word_type)
// response   rsp_valid out, no back-off   rsp_data (response_word_type)
// config     csr_write_enable in          csr_index, csr_write_data
//
// A load is handled in the idle state; it writes one prefix sum to the
// memory if its bin is zero or the next in order below the bin count.
// A query that fails its checks answers in the next cycle; a good query
// keeps busy high for the window bounds, two reads of the single-read
// memory, 37 divider steps and the done flag; it answers in the first idle cycle.
// Reset is synchronous; the prefix memory is not cleared and needs none.
// Responses are shown for one cycle and cannot be stalled.
module log_width_spectral_envelope #(
   parameter int BIN_CAPACITY = 4097
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  lwse_pkg::request_word_type  req_data,
   output logic                        rsp_valid,
   output lwse_pkg::response_word_type rsp_data,
   input  logic                        csr_write_enable,
   input  logic                        csr_index,
   input  logic [lwse_pkg::FRAC_W-1:0] csr_write_data
);

   import lwse_pkg::*;

   localparam int DEPTH  = BIN_CAPACITY + 1;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [BIN_W-1:0] CAP_COUNT = BIN_W'(BIN_CAPACITY);

   lwse_state_type    state_ff, state_in;
   logic [BIN_W-1:0]  bin_count_ff;
   logic [FRAC_W-1:0] width_fraction_ff;
   logic [SUM_W-1:0]  running_sum_ff, running_sum_in;
   logic [BIN_W-1:0]  loaded_count_ff, loaded_count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   response_word_type rsp_data_ff, rsp_data_in;
   logic [BIN_W-1:0]  bin_ff, bin_in;
   logic [BIN_W-1:0]  hw_raw_ff, hw_raw_in;
   logic [BIN_W-1:0]  lo_ff, lo_in;
   logic [BIN_W-1:0]  len_ff, len_in;
   logic [SUM_W-1:0]  hi_sum_ff, hi_sum_in;

   logic [BIN_W-1:0]        eff_count;
   logic [BIN_W+FRAC_W-1:0] product;
   logic [BIN_W-1:0]        hw;
   logic [BIN_W:0]          hi_wide;
   logic [BIN_W-1:0]        hi;
   logic [BIN_W-1:0]        hi_plus_one;
   logic [BIN_W-1:0]        loaded_plus_one;
   logic [SUM_W-1:0]        lo_sum;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [SUM_W-1:0]  wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [SUM_W-1:0]  rd_data;
   logic              div_start;
   logic [SUM_W-1:0]  div_dividend;
   logic              div_done;
   logic [SUM_W-1:0]  div_quotient;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff      <= BIN_COUNT_RESET;
         width_fraction_ff <= WIDTH_FRACTION_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BIN_COUNT:      bin_count_ff      <= csr_write_data[BIN_W-1:0];
            CSR_WIDTH_FRACTION: width_fraction_ff <= csr_write_data;
            default:            bin_count_ff      <= bin_count_ff;
         endcase
      end
   end

   // Bin count saturated to the range the memory holds.
   always_comb begin
      if (bin_count_ff == '0) begin
         eff_count = BIN_W'(1);
      end else if (bin_count_ff > CAP_COUNT) begin
         eff_count = CAP_COUNT;
      end else begin
         eff_count = bin_count_ff;
      end
   end

   // Half-width multiply on the incoming bin, registered before use.
   assign product = req_data.bin_index * width_fraction_ff;

   // Window bounds from the registered half-width.
   always_comb begin
      hw          = (hw_raw_ff < MIN_HALF_WIDTH) ? MIN_HALF_WIDTH : hw_raw_ff;
      lo_in       = (bin_ff >= hw) ? bin_ff - hw : '0;
      hi_wide     = {1'b0, bin_ff} + {1'b0, hw};
      hi          = (hi_wide > {1'b0, eff_count - BIN_W'(1)}) ?
                    eff_count - BIN_W'(1) : hi_wide[BIN_W-1:0];
      hi_plus_one = hi + BIN_W'(1);
      len_in      = hi - lo_in + BIN_W'(1);
   end

   assign loaded_plus_one = loaded_count_ff + BIN_W'(1);
   // The prefix below bin 0 is zero and is never stored.
   assign lo_sum       = (lo_ff == '0) ? '0 : rd_data;
   assign div_dividend = hi_sum_ff - lo_sum;

   // Sequencer: loads and rejected queries finish in the idle cycle, good queries walk the states.
   always_comb begin
      state_in        = state_ff;
      running_sum_in  = running_sum_ff;
      loaded_count_in = loaded_count_ff;
      rsp_valid_in    = 1'b0;
      rsp_data_in     = rsp_data_ff;
      bin_in          = bin_ff;
      hw_raw_in       = hw_raw_ff;
      hi_sum_in       = hi_sum_ff;
      wr_en           = 1'b0;
      wr_addr         = ADDR_W'(1);
      wr_data         = running_sum_ff;
      rd_addr         = lo_ff[ADDR_W-1:0];
      div_start       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_data.req_type == REQ_LOAD) begin
                  if (req_data.bin_index == '0) begin
                     running_sum_in  = SUM_W'(req_data.magnitude);
                     loaded_count_in = BIN_W'(1);
                     wr_en           = 1'b1;
                     wr_addr         = ADDR_W'(1);
                     wr_data         = SUM_W'(req_data.magnitude);
                  end else if (req_data.bin_index == loaded_count_ff &&
                               loaded_count_ff < eff_count) begin
                     running_sum_in  = running_sum_ff + SUM_W'(req_data.magnitude);
                     loaded_count_in = loaded_plus_one;
                     wr_en           = 1'b1;
                     wr_addr         = loaded_plus_one[ADDR_W-1:0];
                     wr_data         = running_sum_ff + SUM_W'(req_data.magnitude);
                  end
               end else if (req_data.bin_index >= eff_count) begin
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.envelope = '0;
                  rsp_data_in.status   = STATUS_RANGE;
               end else if (loaded_count_ff < eff_count) begin
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.envelope = '0;
                  rsp_data_in.status   = STATUS_PENDING;
               end else begin
                  bin_in    = req_data.bin_index;
                  hw_raw_in = product[BIN_W+FRAC_W-1:FRAC_W];
                  state_in  = ST_HALF;
               end
            end
         end
         ST_HALF: begin
            rd_addr  = hi_plus_one[ADDR_W-1:0];
            state_in = ST_READ_HI;
         end
         ST_READ_HI: begin
            hi_sum_in = rd_data;
            rd_addr   = lo_ff[ADDR_W-1:0];
            state_in  = ST_READ_LO;
         end
         ST_READ_LO: begin
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.envelope = div_quotient[MAG_W-1:0];
               rsp_data_in.status   = STATUS_OK;
               state_in             = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         running_sum_ff  <= '0;
         loaded_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         running_sum_ff  <= running_sum_in;
         loaded_count_ff <= loaded_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      bin_ff      <= bin_in;
      hw_raw_ff   <= hw_raw_in;
      hi_sum_ff   <= hi_sum_in;
      if (state_ff == ST_HALF) begin
         lo_ff  <= lo_in;
         len_ff <= len_in;
      end
   end

   // Prefix sums: entry i holds the sum of bins below i.
   lwse_ram #(
      .WIDTH (SUM_W),
      .DEPTH (DEPTH)
   ) u_prefix_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Window sum over window length, one quotient bit a cycle.
   lwse_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (len_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[sim/tb.sv]
module tb;
   import lwse_pkg::*;

   localparam int CAPACITY = 4097;
   localparam int SETTLE_CYCLES = 50;

   // Predicts the envelope words and checks the block's responses in order.
   class envelope_scoreboard;
      logic [SUM_W-1:0]  prefix_sums [0:CAPACITY];
      logic [SUM_W-1:0]  frame_total;
      int unsigned       bins_loaded;
      logic [BIN_W-1:0]  bin_count_reg;
      logic [FRAC_W-1:0] fraction_reg;
      response_word_type expected_envelopes [$];
      int unsigned       failures;
      int unsigned       ok_seen;
      int unsigned       range_seen;
      int unsigned       pending_seen;

      function new();
         foreach (prefix_sums[i]) prefix_sums[i] = '0;
         frame_total   = '0;
         bins_loaded   = 0;
         bin_count_reg = BIN_COUNT_RESET;
         fraction_reg  = WIDTH_FRACTION_RESET;
         failures      = 0;
         ok_seen       = 0;
         range_seen    = 0;
         pending_seen  = 0;
      endfunction

      // Bin count saturated to the range the memory supports.
      function int unsigned frame_length();
         if (bin_count_reg == '0) begin
            return 1;
         end
         if (bin_count_reg > CAPACITY) begin
            return CAPACITY;
         end
         return bin_count_reg;
      endfunction

      function int unsigned pending();
         return expected_envelopes.size();
      endfunction

      function void write_register(logic idx, logic [FRAC_W-1:0] data);
         if (idx == CSR_BIN_COUNT) begin
            bin_count_reg = data[BIN_W-1:0];
         end else begin
            fraction_reg = data;
         end
      endfunction

      // Apply one accepted request word; queries queue their expected answer.
      function void note_request(request_word_type w);
         response_word_type want;
         int unsigned       lim;
         int unsigned       bin;
         int unsigned       half;
         int unsigned       lo;
         int unsigned       hi;
         int unsigned       span;
         logic [28:0]       scaled;
         logic [SUM_W-1:0]  window;
         lim = frame_length();
         bin = w.bin_index;
         if (w.req_type == REQ_LOAD) begin
            // A load at bin zero always opens a new frame.
            if (bin == 0) begin
               prefix_sums[0] = '0;
               frame_total    = SUM_W'(w.magnitude);
               prefix_sums[1] = frame_total;
               bins_loaded    = 1;
            end else if (bin == bins_loaded && bins_loaded < lim) begin
               frame_total = frame_total + SUM_W'(w.magnitude);
               bins_loaded++;
               prefix_sums[bins_loaded] = frame_total;
            end
            return;
         end
         want.envelope = '0;
         if (bin >= lim) begin
            want.status = STATUS_RANGE;
         end else if (bins_loaded < lim) begin
            want.status = STATUS_PENDING;
         end else begin
            // Half-width grows with the bin, never below the minimum.
            scaled = 29'(bin) * 29'(fraction_reg);
            half   = scaled[28:16];
            if (half < MIN_HALF_WIDTH) begin
               half = MIN_HALF_WIDTH;
            end
            lo = (bin >= half) ? bin - half : 0;
            hi = bin + half;
            if (hi > lim - 1) begin
               hi = lim - 1;
            end
            span          = hi - lo + 1;
            window        = prefix_sums[hi + 1] - prefix_sums[lo];
            want.envelope = MAG_W'(window / SUM_W'(span));
            want.status   = STATUS_OK;
         end
         expected_envelopes = {expected_envelopes, want};
      endfunction

      function void check_response(response_word_type got);
         response_word_type want;
         if (expected_envelopes.size() == 0) begin
            $error("response with no query outstanding: envelope %h status %0d",
                   got.envelope, got.status);
            failures++;
            return;
         end
         want = expected_envelopes.pop_front();
         if (got.envelope !== want.envelope) begin
            $error("envelope: expected %h, got %h", want.envelope, got.envelope);
            failures++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            failures++;
         end
         case (want.status)
            STATUS_OK:    ok_seen++;
            STATUS_RANGE: range_seen++;
            default:      pending_seen++;
         endcase
      endfunction

      function void close_out();
         if (expected_envelopes.size() != 0) begin
            $error("%0d queries never answered", expected_envelopes.size());
            failures++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   request_word_type  req_data;
   logic              rsp_valid;
   response_word_type rsp_data;
   logic              csr_write_enable;
   logic              csr_index;
   logic [FRAC_W-1:0] csr_write_data;

   envelope_scoreboard sb;
   int unsigned        words_sent;
   int unsigned        traffic_items;

   log_width_spectral_envelope #(
      .BIN_CAPACITY(CAPACITY)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   // Observe both channels and the register port at every rising edge.
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_valid !== 1'b0) begin
            sb.check_response(rsp_data);
         end
         if (start === 1'b1 && busy === 1'b0) begin
            sb.note_request(req_data);
         end
         if (csr_write_enable === 1'b1) begin
            sb.write_register(csr_index, csr_write_data);
         end
      end
   end

   // Present one word, with an occasional gap first, and hold it until taken.
   task automatic send_word(input request_word_type w);
      int unsigned gap;
      words_sent++;
      if ((words_sent < 400 || words_sent >= 900) && $urandom_range(0, 99) < 19) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= w;
      start    <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic load_bin(input int unsigned bin, input logic [MAG_W-1:0] mag);
      send_word('{req_type: REQ_LOAD, bin_index: BIN_W'(bin), magnitude: mag});
   endtask

   task automatic query_bin(input int unsigned bin);
      send_word('{req_type: REQ_QUERY, bin_index: BIN_W'(bin),
                  magnitude: MAG_W'($urandom())});
   endtask

   // Drain all answers and wait for the block to go idle, then settle further.
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(input logic [FRAC_W-1:0] count_data,
                               input logic [FRAC_W-1:0] frac_data);
      settle();
      csr_index        <= CSR_BIN_COUNT;
      csr_write_data   <= count_data;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_index        <= CSR_WIDTH_FRACTION;
      csr_write_data   <= frac_data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // One register setting: frames of loads mixed with queries and some noise.
   // The frame in memory may be continued under the new count or restarted.
   task automatic run_phase(input logic [FRAC_W-1:0] count_data,
                            input logic [FRAC_W-1:0] frac_data,
                            input int unsigned budget,
                            input int unsigned load_pct,
                            input int unsigned noise_pct);
      int unsigned      lim;
      int unsigned      next_bin;
      int unsigned      done;
      int unsigned      roll;
      int unsigned      bin;
      logic [1:0]       mag_style;
      logic [MAG_W-1:0] mag;
      program_regs(count_data, frac_data);
      lim      = sb.frame_length();
      next_bin = sb.bins_loaded;
      if (noise_pct != 0 && $urandom_range(0, 1) == 0) begin
         next_bin = 0;
      end
      if (next_bin > lim) begin
         next_bin = lim;
      end
      mag_style = (lim > 500) ? 2'd3 : 2'($urandom_range(0, 3));
      done = 0;
      while (done < budget) begin
         roll = $urandom_range(0, 99);
         if (next_bin < lim && roll < load_pct) begin
            roll = $urandom_range(0, 99);
            if (next_bin != 0 && roll < noise_pct) begin
               // Out-of-order load that the block must ignore.
               bin = $urandom_range(1, 8190);
               if (bin >= next_bin) begin
                  bin++;
               end
               load_bin(bin, MAG_W'($urandom()));
            end else begin
               // Now and then the frame restarts before it is complete.
               if (noise_pct != 0 && next_bin != 0 && roll < noise_pct + 2) begin
                  next_bin = 0;
               end
               case (mag_style)
                  2'd0:    mag = MAG_W'($urandom());
                  2'd1:    mag = '1;
                  2'd2:    mag = MAG_W'($urandom_range(0, 255));
                  default: mag = ($urandom_range(0, 99) < 75) ? '1 : MAG_W'($urandom());
               endcase
               load_bin(next_bin, mag);
               next_bin++;
               done++;
            end
         end else if (next_bin >= lim && noise_pct != 0 && roll > 96) begin
            // Load past the end of a complete frame.
            load_bin(lim, MAG_W'($urandom()));
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
               bin = $urandom_range(0, lim - 1);
            end else if (roll < 85) begin
               bin = $urandom_range(lim, 8191);
            end else begin
               case ($urandom_range(0, 3))
                  0:       bin = 0;
                  1:       bin = lim - 1;
                  2:       bin = lim;
                  default: bin = 8191;
               endcase
            end
            query_bin(bin);
            done++;
            if (next_bin >= lim && noise_pct != 0 && $urandom_range(0, 99) < 3) begin
               next_bin  = 0;
               mag_style = 2'($urandom_range(0, 3));
            end
         end
      end
      traffic_items += done;
   endtask

   initial begin
      logic [FRAC_W-1:0] count_data;
      logic [FRAC_W-1:0] frac_data;
      sb               = new();
      words_sent       = 0;
      traffic_items    = 0;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_data         <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_BIN_COUNT;
      csr_write_data   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset count: just beyond it is out of range, just inside is unloaded.
      query_bin(1025);
      query_bin(1024);

      // Short frame of eight bins with a fraction of 3277.
      program_regs(16'd8, 16'd3277);
      query_bin(0);
      query_bin(8191);
      query_bin(8);
      load_bin(0, '1);
      load_bin(1, '0);
      load_bin(2, '1);
      load_bin(5, 24'h5A5A5A);
      load_bin(3, 24'h000001);
      query_bin(0);
      load_bin(4, '1);
      load_bin(5, 24'h800000);
      load_bin(6, '0);
      load_bin(7, '1);
      load_bin(8, '1);
      query_bin(0);
      query_bin(7);
      query_bin(3);
      query_bin(4);
      query_bin(8);
      load_bin(0, 24'h123456);
      query_bin(0);

      // Extremes of both registers, then random small settings.
      run_phase(16'h0001, 16'd3277, 60, 70, 5);
      run_phase(16'h0000, 16'hFFFF, 60, 70, 5);
      run_phase(16'hE002, 16'h0000, 60, 70, 5);
      run_phase(16'd5, 16'd32768, 80, 70, 5);
      run_phase(16'd17, FRAC_W'($urandom()), 100, 75, 5);
      run_phase(16'd64, 16'd32768, 150, 80, 5);
      while (traffic_items < 600) begin
         count_data = {3'($urandom_range(0, 7)), 13'($urandom_range(1, 48))};
         frac_data  = ($urandom_range(0, 1) == 0) ? FRAC_W'($urandom_range(3277, 32768))
                                                  : FRAC_W'($urandom());
         run_phase(count_data, frac_data, $urandom_range(60, 120), 75, 5);
      end

      // One long frame, then queried under other fractions and counts.
      run_phase(16'd600, 16'd32768, 700, 99, 0);
      run_phase(16'd600, 16'd3277, 40, 99, 0);
      run_phase(16'hFFFF, 16'h0000, 25, 99, 0);
      run_phase(16'd600, 16'hFFFF, 25, 99, 0);

      // Wait out the last answers, with a bound.
      start <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 400 && sb.pending() != 0; i++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.close_out();
      $display("Sent %0d words; answers: %0d windows, %0d out of range, %0d unloaded frame.",
               words_sent, sb.ok_seen, sb.range_seen, sb.pending_seen);
      if (sb.failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Hard stop well past the slowest correct run.
   initial begin
      #1200000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
